>>> sv/spbt_pkg.sv
// ----------------------------------------------------------------------------
// Stereo peak bucket tracker package
// Shared types and constants for the min/max peak decimation block.
// ----------------------------------------------------------------------------
`default_nettype none

package spbt_pkg;

  // Clamped sample in Q2.20, range -1.0 to +1.0.
  localparam int PEAK_W = 22;
  // Bucket width register and frame count.
  localparam int WIDTH_W = 16;
  // Bucket index, wraps at 2^24.
  localparam int BUCKET_W = 24;
  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  // Signed domain wide enough for any supported sample width.
  localparam int EXT_W = 33;

  typedef logic signed [PEAK_W-1:0] peak_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic signed [EXT_W-1:0] ext_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_BUCKET_WIDTH = 2'd0;
  localparam cfg_idx_t CFG_STEREO_MODE = 2'd1;

  // Plus and minus 1.0 in Q2.20.
  localparam peak_t PEAK_POS_ONE = 22'sd1048576;
  localparam peak_t PEAK_NEG_ONE = -22'sd1048576;
  localparam ext_t EXT_POS_ONE = 33'sd1048576;
  localparam ext_t EXT_NEG_ONE = -33'sd1048576;

  // Saturate a sign-extended sample to +/-1.0.
  function automatic peak_t clamp_sample(input ext_t s);
    peak_t res;
    if (s > EXT_POS_ONE) begin
      res = PEAK_POS_ONE;
    end else if (s < EXT_NEG_ONE) begin
      res = PEAK_NEG_ONE;
    end else begin
      res = s[PEAK_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/stereo_peak_bucket_tracker_core.sv
// ----------------------------------------------------------------------------
// Stereo peak bucket tracker core
// Min/max peak decimation of a stereo audio stream into overview buckets.
// ----------------------------------------------------------------------------
// One frame (left and right sample, final flag) is taken per cycle. The frame
// is held in an input register, clamped to +/-1.0 and folded into the running
// per-channel minimum and maximum in the next cycle; when a bucket fills or the
// final frame arrives, one overview entry lands in the output register, which
// follows the input register with no stage between them. The sustained rate
// is one frame per cycle, set by the single input register feeding the
// compare-and-count logic; it drops only while a finished entry waits in the
// output register and the next frame would close another bucket. A width of 0
// acts as 1. Configuration is taken at any time but must only be written while
// no frame is in flight.
`default_nettype none

module stereo_peak_bucket_tracker_core #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Configuration writes.
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire spbt_pkg::cfg_idx_t       cfg_index,
  input  wire spbt_pkg::cfg_data_t      cfg_data,
  // Frame input.
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_right_sample,
  input  wire logic                     in_final_frame,
  // Overview entries.
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output spbt_pkg::bucket_t             out_bucket_number,
  output spbt_pkg::peak_t               out_left_minimum,
  output spbt_pkg::peak_t               out_left_maximum,
  output spbt_pkg::peak_t               out_right_minimum,
  output spbt_pkg::peak_t               out_right_maximum,
  output logic                          out_is_final_bucket
);

  import spbt_pkg::*;

  // Configuration registers.
  width_t bucket_width_r;
  logic   stereo_mode_r;

  // Input stage.
  logic                           s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] s1_left_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_right_r;
  logic                           s1_final_r;

  // Bucket state.
  width_t  frames_r, frames_nxt;
  bucket_t bucket_r, bucket_nxt;
  peak_t   lmin_r, lmin_nxt;
  peak_t   lmax_r, lmax_nxt;
  peak_t   rmin_r, rmin_nxt;
  peak_t   rmax_r, rmax_nxt;

  // Output register.
  logic    out_valid_r, out_valid_nxt;
  bucket_t out_bucket_r;
  peak_t   out_lmin_r, out_lmax_r, out_rmin_r, out_rmax_r;
  logic    out_final_r;

  // Datapath.
  peak_t                left_clamped, right_clamped;
  peak_t                lmin_upd, lmax_upd, rmin_upd, rmax_upd;
  logic [WIDTH_W:0]     held;
  logic [WIDTH_W:0]     width_eff;
  logic                 emit;
  logic                 s1_advance;
  logic                 in_accept;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_width_r <= width_t'(1);
      stereo_mode_r  <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BUCKET_WIDTH) begin
        bucket_width_r <= cfg_data;
      end else if (cfg_index == CFG_STEREO_MODE) begin
        stereo_mode_r <= cfg_data[0];
      end
    end
  end

  // Clamp and fold the held frame into the running extremes.
  always_comb begin
    left_clamped  = clamp_sample(ext_t'(s1_left_r));
    right_clamped = clamp_sample(ext_t'(s1_right_r));
    lmin_upd = (left_clamped < lmin_r) ? left_clamped : lmin_r;
    lmax_upd = (left_clamped > lmax_r) ? left_clamped : lmax_r;
    rmin_upd = rmin_r;
    rmax_upd = rmax_r;
    if (stereo_mode_r) begin
      rmin_upd = (right_clamped < rmin_r) ? right_clamped : rmin_r;
      rmax_upd = (right_clamped > rmax_r) ? right_clamped : rmax_r;
    end
    held      = {1'b0, frames_r} + (WIDTH_W+1)'(1);
    width_eff = (bucket_width_r == '0) ? (WIDTH_W+1)'(1) : {1'b0, bucket_width_r};
    emit      = (held >= width_eff) || s1_final_r;
  end

  // A frame leaves the input stage unless its entry finds the output full.
  assign s1_advance = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_accept  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = (out_valid_r && !out_ready) || (s1_advance && emit);
    frames_nxt    = frames_r;
    bucket_nxt    = bucket_r;
    lmin_nxt      = lmin_r;
    lmax_nxt      = lmax_r;
    rmin_nxt      = rmin_r;
    rmax_nxt      = rmax_r;
    if (s1_advance) begin
      if (emit) begin
        frames_nxt = '0;
        bucket_nxt = s1_final_r ? '0 : bucket_r + bucket_t'(1);
        lmin_nxt   = PEAK_POS_ONE;
        lmax_nxt   = PEAK_NEG_ONE;
        rmin_nxt   = PEAK_POS_ONE;
        rmax_nxt   = PEAK_NEG_ONE;
      end else begin
        frames_nxt = held[WIDTH_W-1:0];
        lmin_nxt   = lmin_upd;
        lmax_nxt   = lmax_upd;
        rmin_nxt   = rmin_upd;
        rmax_nxt   = rmax_upd;
      end
    end
  end

  // Control and bucket state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      frames_r    <= '0;
      bucket_r    <= '0;
      lmin_r      <= PEAK_POS_ONE;
      lmax_r      <= PEAK_NEG_ONE;
      rmin_r      <= PEAK_POS_ONE;
      rmax_r      <= PEAK_NEG_ONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      frames_r    <= frames_nxt;
      bucket_r    <= bucket_nxt;
      lmin_r      <= lmin_nxt;
      lmax_r      <= lmax_nxt;
      rmin_r      <= rmin_nxt;
      rmax_r      <= rmax_nxt;
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_left_r  <= in_left_sample;
      s1_right_r <= in_right_sample;
      s1_final_r <= in_final_frame;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      out_bucket_r <= bucket_r;
      out_lmin_r   <= lmin_upd;
      out_lmax_r   <= lmax_upd;
      out_rmin_r   <= stereo_mode_r ? rmin_upd : '0;
      out_rmax_r   <= stereo_mode_r ? rmax_upd : '0;
      out_final_r  <= s1_final_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bucket_number   = out_bucket_r;
  assign out_left_minimum    = out_lmin_r;
  assign out_left_maximum    = out_lmax_r;
  assign out_right_minimum   = out_rmin_r;
  assign out_right_maximum   = out_rmax_r;
  assign out_is_final_bucket = out_final_r;

`ifndef SYNTHESIS
  // A closed bucket leaves the running extremes at their empty values.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && emit) |=> (frames_r == '0) && (lmin_r == PEAK_POS_ONE) &&
      (lmax_r == PEAK_NEG_ONE))
    else $error("running state not cleared after a closed bucket");

  // The final frame restarts the bucket index at zero.
  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && emit && s1_final_r) |=> (bucket_r == '0))
    else $error("bucket index not restarted after the final frame");

  // A frame that does not close a bucket adds one to the frame count.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && !emit) |=> (frames_r == $past(held[WIDTH_W-1:0])))
    else $error("frame count did not advance");

  // Left extremes of a reported entry stay within +/-1.0.
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_lmin_r >= PEAK_NEG_ONE) && (out_lmin_r <= PEAK_POS_ONE) &&
      (out_lmax_r >= PEAK_NEG_ONE) && (out_lmax_r <= PEAK_POS_ONE))
    else $error("reported left extreme out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo peak bucket tracker testbench
// Streams audio frames into the peak decimation core and checks every
// overview entry against a cycle-free predictor kept in the bench.
// ----------------------------------------------------------------------------
// A directed part covers clamping extremes, zero and maximum bucket widths,
// partial and final buckets, a width lowered inside a bucket and mono/stereo
// switches inside a bucket. A random part then runs many short streams under
// changing settings, with random gaps on the frame side and random stalls on
// the entry side, plus one long receiver hold that backs the core up.
// ----------------------------------------------------------------------------

module tb;
  import spbt_pkg::*;

  localparam int SAMPLE_W = 24;
  localparam int ONE_Q20 = 1 << 20;
  localparam int RANDOM_FRAMES = 1450;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One overview entry as the core reports it.
  typedef struct {
    bucket_t bucket;
    peak_t   left_lo;
    peak_t   left_hi;
    peak_t   right_lo;
    peak_t   right_hi;
    logic    last;
  } overview_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;
  logic      in_valid;
  logic      in_ready;
  sample_t   in_left_sample;
  sample_t   in_right_sample;
  logic      in_final_frame;
  logic      out_valid;
  logic      out_ready;
  bucket_t   out_bucket_number;
  peak_t     out_left_minimum;
  peak_t     out_left_maximum;
  peak_t     out_right_minimum;
  peak_t     out_right_maximum;
  logic      out_is_final_bucket;

  stereo_peak_bucket_tracker_core #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_left_sample     (in_left_sample),
    .in_right_sample    (in_right_sample),
    .in_final_frame     (in_final_frame),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bucket_number  (out_bucket_number),
    .out_left_minimum   (out_left_minimum),
    .out_left_maximum   (out_left_maximum),
    .out_right_minimum  (out_right_minimum),
    .out_right_maximum  (out_right_maximum),
    .out_is_final_bucket(out_is_final_bucket)
  );

  // Predictor copy of the registers and the bucket state.
  width_t  width_reg;
  logic    stereo_reg;
  int      fill_count;
  bucket_t bucket_idx;
  peak_t   left_lo;
  peak_t   left_hi;
  peak_t   right_lo;
  peak_t   right_hi;

  overview_t pending_entries[$];
  overview_t want;

  int  errors;
  int  frames_sent;
  int  entries_seen;
  int  reg_writes;
  bit  tx_busy;
  bit  rx_busy;
  int  rx_hold_req;

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Random idle length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  // Sign-extended sample saturated to +/-1.0.
  function automatic peak_t saturate_q20(input sample_t s);
    int w;
    w = s;
    if (w > ONE_Q20) begin
      return PEAK_POS_ONE;
    end else if (w < -ONE_Q20) begin
      return PEAK_NEG_ONE;
    end
    return peak_t'(w);
  endfunction

  // Random sample: full range, in range, or right at the clamp edges.
  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return sample_t'($urandom);
    end else if (r < 8) begin
      return sample_t'(int'($urandom_range(0, 2 * ONE_Q20)) - ONE_Q20);
    end
    case ($urandom_range(0, 5))
      0: return sample_t'(ONE_Q20);
      1: return sample_t'(-ONE_Q20);
      2: return sample_t'(ONE_Q20 + 1);
      3: return sample_t'(-ONE_Q20 - 1);
      4: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      default: return {1'b1, {(SAMPLE_W-1){1'b0}}};
    endcase
  endfunction

  // Reset the running extremes of the current bucket.
  function automatic void clear_extremes();
    left_lo  = PEAK_POS_ONE;
    left_hi  = PEAK_NEG_ONE;
    right_lo = PEAK_POS_ONE;
    right_hi = PEAK_NEG_ONE;
  endfunction

  // Fold one accepted frame into the bucket; queue an entry when it closes.
  function automatic void fold_frame(input sample_t l_raw, input sample_t r_raw,
                                     input logic last);
    peak_t     l;
    peak_t     r;
    overview_t e;
    int        span;
    l = saturate_q20(l_raw);
    r = saturate_q20(r_raw);
    span = (width_reg == '0) ? 1 : int'(width_reg);
    if (l < left_lo) left_lo = l;
    if (l > left_hi) left_hi = l;
    if (stereo_reg) begin
      if (r < right_lo) right_lo = r;
      if (r > right_hi) right_hi = r;
    end
    if (fill_count + 1 < span && !last) begin
      fill_count++;
      return;
    end
    e.bucket   = bucket_idx;
    e.left_lo  = left_lo;
    e.left_hi  = left_hi;
    e.right_lo = stereo_reg ? right_lo : '0;
    e.right_hi = stereo_reg ? right_hi : '0;
    e.last     = last;
    pending_entries.push_back(e);
    clear_extremes();
    fill_count = 0;
    bucket_idx = last ? '0 : bucket_idx + 1'b1;
  endfunction

  // Offer one frame, hold it until taken, then predict its effect.
  task automatic send_frame(input sample_t l, input sample_t r, input logic last);
    int gap;
    if (tx_busy && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    in_final_frame  <= last;
    do @(posedge clk); while (!in_ready);
    fold_frame(l, r, last);
    frames_sent++;
  endtask

  // Stop offering frames and let every expected entry drain.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    // A frame that closes no bucket may still be in the pipeline.
    repeat (4) @(posedge clk);
  endtask

  // One register write; only called while the core is idle.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BUCKET_WIDTH: width_reg = data;
      CFG_STEREO_MODE:  stereo_reg = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Entry checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected overview entry, bucket %0d", $time, out_bucket_number);
        errors++;
      end else begin
        want = pending_entries.pop_front();
        check_field("bucket_number", want.bucket, out_bucket_number);
        check_field("left_minimum", want.left_lo, out_left_minimum);
        check_field("left_maximum", want.left_hi, out_left_maximum);
        check_field("right_minimum", want.right_lo, out_right_minimum);
        check_field("right_maximum", want.right_hi, out_right_maximum);
        check_field("is_final_bucket", want.last, out_is_final_bucket);
        entries_seen++;
      end
    end
  end

  // Entry receiver: random stalls, plus a long hold when one is requested.
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (rx_busy && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Reset defaults (width 1, stereo): every frame is a bucket; clamp extremes.
  task automatic test_clamp_extremes();
    send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
    send_frame(sample_t'(ONE_Q20), sample_t'(-ONE_Q20), 1'b0);
    send_frame(sample_t'(ONE_Q20 + 1), sample_t'(-ONE_Q20 - 1), 1'b0);
    send_frame(sample_t'(ONE_Q20 - 1), sample_t'(-ONE_Q20 + 1), 1'b0);
    send_frame('0, '1, 1'b0);
    send_frame(24'sh800000, 24'sh7FFFFF, 1'b1);
    wait_idle();
  endtask

  // Zero width acts as one; full, partial and single-frame final buckets;
  // the widest bucket closed early by a final frame.
  task automatic test_bucket_widths();
    write_reg(CFG_BUCKET_WIDTH, '0);
    send_frame(sample_t'(5), sample_t'(-5), 1'b0);
    wait_idle();
    write_reg(CFG_BUCKET_WIDTH, 16'd3);
    send_frame(sample_t'(100), sample_t'(-300), 1'b0);
    send_frame(sample_t'(-200), sample_t'(400), 1'b0);
    send_frame(sample_t'(50), sample_t'(0), 1'b0);
    send_frame(sample_t'(7), sample_t'(8), 1'b0);
    send_frame(sample_t'(-7), sample_t'(-8), 1'b1);
    send_frame(sample_t'(9), sample_t'(-9), 1'b1);
    wait_idle();
    write_reg(CFG_BUCKET_WIDTH, 16'hFFFF);
    send_frame(sample_t'(ONE_Q20 * 3), sample_t'(12345), 1'b0);
    send_frame(sample_t'(-ONE_Q20 * 3), sample_t'(-12345), 1'b1);
    wait_idle();
  endtask

  // Width lowered below the frames already held: the next frame closes it.
  task automatic test_width_lowered();
    write_reg(CFG_BUCKET_WIDTH, 16'd6);
    send_frame(sample_t'(11), sample_t'(-11), 1'b0);
    send_frame(sample_t'(22), sample_t'(-22), 1'b0);
    send_frame(sample_t'(33), sample_t'(-33), 1'b0);
    wait_idle();
    write_reg(CFG_BUCKET_WIDTH, 16'd2);
    send_frame(sample_t'(-44), sample_t'(44), 1'b0);
    wait_idle();
  endtask

  // Stereo to mono inside a bucket, then mono to stereo inside a bucket.
  task automatic test_mode_switch();
    write_reg(CFG_BUCKET_WIDTH, 16'd3);
    write_reg(CFG_STEREO_MODE, 16'd1);
    send_frame(sample_t'(1000), sample_t'(-2000), 1'b0);
    wait_idle();
    write_reg(CFG_STEREO_MODE, 16'd0);
    send_frame(sample_t'(-1000), sample_t'(3000), 1'b0);
    send_frame(sample_t'(500), sample_t'(-4000), 1'b0);
    send_frame(sample_t'(600), sample_t'(ONE_Q20), 1'b0);
    wait_idle();
    write_reg(CFG_STEREO_MODE, 16'd1);
    send_frame(sample_t'(700), sample_t'(-70), 1'b0);
    send_frame(sample_t'(800), sample_t'(80), 1'b0);
    wait_idle();
  endtask

  // Long receiver hold while frames keep coming, so the core stalls its input.
  task automatic test_backpressure();
    write_reg(CFG_BUCKET_WIDTH, 16'd1);
    write_reg(CFG_STEREO_MODE, 16'd1);
    tx_busy = 1'b0;
    rx_busy = 1'b0;
    rx_hold_req = 300;
    repeat (40) send_frame(rand_sample(), rand_sample(), $urandom_range(0, 9) == 0);
    wait_idle();
  endtask

  // Random streams under changing settings and handshake behavior.
  task automatic test_random_streams();
    int     sent;
    int     run_len;
    int     pick;
    width_t w;
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        w = width_t'($urandom_range(1, 4));
      end else if (pick < 70) begin
        w = width_t'($urandom_range(5, 16));
      end else if (pick < 80) begin
        w = width_t'($urandom_range(0, 1));
      end else if (pick < 95) begin
        w = width_t'($urandom_range(17, 300));
      end else begin
        w = 16'hFFFF;
      end
      if ($urandom_range(0, 3) != 0) write_reg(CFG_BUCKET_WIDTH, w);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_STEREO_MODE, cfg_data_t'($urandom_range(0, 1)));
      end
      tx_busy = $urandom_range(0, 3) != 0;
      rx_busy = $urandom_range(0, 3) != 0;
      run_len = $urandom_range(10, 60);
      repeat (run_len) begin
        send_frame(rand_sample(), rand_sample(), $urandom_range(0, 24) == 0);
        sent++;
      end
    end
    wait_idle();
  endtask

  // Run limit.
  initial begin
    #(20_000_000);
    $display("Run limit reached with %0d entries outstanding", pending_entries.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_left_sample = '0;
    in_right_sample = '0;
    in_final_frame = 1'b0;
    width_reg = 16'd1;
    stereo_reg = 1'b1;
    fill_count = 0;
    bucket_idx = '0;
    clear_extremes();
    errors = 0;
    frames_sent = 0;
    entries_seen = 0;
    reg_writes = 0;
    tx_busy = 1'b0;
    rx_busy = 1'b0;
    rx_hold_req = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_clamp_extremes();
    test_bucket_widths();
    test_width_lowered();
    test_mode_switch();
    test_backpressure();
    test_random_streams();

    repeat (10) @(posedge clk);
    $display("Sent %0d frames, checked %0d overview entries, %0d register writes.",
             frames_sent, entries_seen, reg_writes);
    $display("Covered clamp edges, zero and widest widths, final buckets and mode switches.");
    if (errors == 0 && pending_entries.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
